// ===== sv/lrme_pkg.sv =====
// ----------------------------------------------------------------------------
// lrme_pkg
// Shared types, widths, codes and the mu-law threshold and expansion tables of
// the LPC residual mu-law encoder. Both tables are built at elaboration with
// exact wide integer arithmetic.
// ----------------------------------------------------------------------------
package lrme_pkg;

  // Field and datapath widths
  localparam int COEF_W   = 16;  // Q3.12 coefficient
  localparam int SAMPLE_W = 16;  // PCM sample
  localparam int HIST_W   = 24;  // Q19.4 history and prediction
  localparam int CODE_W   = 8;   // mu-law code
  localparam int X_W      = 26;  // residual, wide enough for 16*sample - p
  localparam int MAG_W    = 25;  // magnitude of a residual
  localparam int DEC_W    = 20;  // expanded magnitude, up to 2^19
  localparam int ORDER_DEF = 16;

  localparam int HIST_MAX = 8388607;
  localparam int HIST_MIN = -8388608;

  // Mode codes of an input beat
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Code of a zero value
  localparam logic [CODE_W-1:0] CODE_ZERO = 8'd128;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_ESTART,
    S_EWAIT,
    S_OUT
  } lrme_state_t;

  // Encoder status seen by the sequencer
  typedef struct packed {
    logic              busy;
    logic [CODE_W-1:0] code;
  } enc_status_t;

  // Wide scratch width for the table builders
  localparam int PW = 1088;

  // n squared s times, that is n^(2^s)
  function automatic logic [PW-1:0] pow_sq(input logic [PW-1:0] n, input int s);
    logic [PW-1:0] a;
    a = n;
    for (int k = 0; k < s; k++) begin
      a = a * a;
    end
    return a;
  endfunction

  // Encode thresholds: entry m is the smallest magnitude whose code step is
  // at least m, i.e. (2^19 + 255*mag)^32 >= 2^(607 + 2m). Entry 0 is zero,
  // entries above 128 can never be reached.
  function automatic logic [255:0][MAG_W-1:0] build_enc_thr();
    logic [255:0][MAG_W-1:0] t;
    longint lo;
    longint hi;
    longint mid;
    logic [PW-1:0] lim;
    logic [PW-1:0] nn;
    for (int m = 0; m < 256; m++) begin
      if (m == 0) begin
        t[m] = '0;
      end else if (m > 128) begin
        t[m] = '1;
      end else begin
        lim = PW'(1) << (607 + 2 * m);
        lo  = 0;
        hi  = longint'(1) << MAG_W;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          nn  = PW'(longint'(524288) + longint'(255) * mid);
          if (pow_sq(nn, 5) >= lim) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        if (lo >= (longint'(1) << MAG_W)) begin
          t[m] = '1;
        end else begin
          t[m] = MAG_W'(lo);
        end
      end
    end
    return t;
  endfunction

  // Expansion magnitudes: entry m is round(16*(32768/255)*(256^(m/128)-1)),
  // found as the largest mag with (510*mag + 2^20 - 255)^16 < 2^(320+m).
  function automatic logic [128:0][DEC_W-1:0] build_dec_mag();
    logic [128:0][DEC_W-1:0] d;
    longint lo;
    longint hi;
    longint mid;
    logic [PW-1:0] lim;
    logic [PW-1:0] mm;
    for (int m = 0; m <= 128; m++) begin
      lim = PW'(1) << (320 + m);
      lo  = 0;
      hi  = 524288;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        mm  = PW'(longint'(510) * mid + longint'(1048576) - longint'(255));
        if (pow_sq(mm, 4) < lim) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      d[m] = DEC_W'(lo);
    end
    return d;
  endfunction

  localparam logic [255:0][MAG_W-1:0] ENC_THR = build_enc_thr();
  localparam logic [128:0][DEC_W-1:0] DEC_MAG = build_dec_mag();

endpackage

// ===== sv/lrme_ram.sv =====
// ----------------------------------------------------------------------------
// lrme_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lrme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lrme_mulaw_enc.sv =====
// ----------------------------------------------------------------------------
// lrme_mulaw_enc
// Iterative mu-law compressor: a binary search over the threshold table, one
// code bit per cycle from the most significant bit down.
// ----------------------------------------------------------------------------
module lrme_mulaw_enc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [lrme_pkg::X_W-1:0] value,
  output lrme_pkg::enc_status_t           status
);
  import lrme_pkg::*;

  logic                    busy;
  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [CODE_W-1:0]       cnt;
  logic [2:0]              bidx;
  logic [CODE_W-1:0]       code;

  logic [X_W-1:0]          abs_val;
  logic [CODE_W-1:0]       trial;
  logic [CODE_W-1:0]       cnt_next;
  logic [CODE_W-1:0]       code_next;

  // magnitude of the incoming value
  assign abs_val = value[X_W-1] ? X_W'(-value) : X_W'(value);

  // one search step: keep the trial bit if the magnitude reaches its threshold
  always_comb begin
    trial    = cnt | (CODE_W'(1) << bidx);
    cnt_next = (mag >= ENC_THR[trial]) ? trial : cnt;
    if (neg) begin
      code_next = CODE_W'(9'(CODE_ZERO) - 9'(cnt_next));
    end else if (cnt_next > 8'd127) begin
      code_next = '1;
    end else begin
      code_next = CODE_W'(9'(CODE_ZERO) + 9'(cnt_next));
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bidx == 3'd0) begin
      busy <= 1'b0;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= value[X_W-1];
      mag  <= abs_val[MAG_W-1:0];
      cnt  <= '0;
      bidx <= 3'd7;
    end else if (busy) begin
      cnt  <= cnt_next;
      bidx <= bidx - 3'd1;
      if (bidx == 3'd0) begin
        code <= code_next;
      end
    end
  end

  assign status.busy = busy;
  assign status.code = code;

endmodule

// ===== sv/lpc_residual_mulaw_encoder_top.sv =====
// ----------------------------------------------------------------------------
// lpc_residual_mulaw_encoder_top
// Closed-loop LPC residual coder with continuous mu-law codes.
//
// A load beat (mode 0) writes one Q3.12 prediction coefficient; an index at
// or beyond ORDER is dropped. For a sample beat (mode 1), one shared 16x24
// multiplier walks the coefficient and history memories one tap per cycle
// while the newest history value is compressed, then the prediction is
// rounded, and the prediction and residual are compressed by eight-step
// binary searches over the threshold table. Each sample beat gives one
// result beat of four codes. The history is a circular buffer in RAM, so
// the shift costs one write. Both memories read as zero until written,
// through per-entry valid bits; no clearing pass is needed after reset. A
// finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module lpc_residual_mulaw_encoder_top #(
  parameter int ORDER = lrme_pkg::ORDER_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 mode,
  input  logic [3:0]                           coef_index,
  input  logic signed [lrme_pkg::COEF_W-1:0]   coef_value,
  input  logic signed [lrme_pkg::SAMPLE_W-1:0] sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [lrme_pkg::CODE_W-1:0]          signal_code,
  output logic [lrme_pkg::CODE_W-1:0]          prediction_code,
  output logic [lrme_pkg::CODE_W-1:0]          previous_excitation,
  output logic [lrme_pkg::CODE_W-1:0]          target_excitation
);
  import lrme_pkg::*;

  localparam int AW     = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int CW     = $clog2(ORDER + 1);
  localparam int PROD_W = COEF_W + HIST_W;
  localparam int ACC_W  = PROD_W + CW;
  localparam int RND_W  = ACC_W + 2;

  lrme_state_t state;
  lrme_state_t state_next;

  // control and pointers
  logic [ORDER-1:0]           coef_valid;
  logic [ORDER-1:0]           hist_valid;
  logic [AW-1:0]              head;
  logic [AW-1:0]              head_new;
  logic [AW-1:0]              rd_ptr;
  logic [CW-1:0]              rd_cnt;
  logic                       s1_vld;
  logic                       s1_tap0;
  logic                       s2_vld;
  logic                       cv1;
  logic                       hv1;
  logic [CODE_W-1:0]          last_exc;

  // datapath
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [HIST_W-1:0]   p_reg;

  logic                       accept;
  logic                       coef_load;
  logic                       issue;
  logic                       out_free;
  logic                       out_load;
  logic                       enc_start;

  logic [COEF_W-1:0]          coef_rdata;
  logic [HIST_W-1:0]          hist_rdata;
  logic signed [COEF_W-1:0]   coef_op;
  logic signed [HIST_W-1:0]   hist_op;

  logic signed [RND_W-1:0]    rnd_sum;
  logic signed [RND_W-1:0]    p_full;
  logic signed [HIST_W-1:0]   p_sat;
  logic signed [X_W-1:0]      x_val;

  logic [CODE_W-1:0]          exc;
  logic [CODE_W-1:0]          dec_idx;
  logic signed [DEC_W:0]      dec_val;
  logic signed [HIST_W:0]     hsum;
  logic signed [HIST_W-1:0]   h_sat;

  enc_status_t                sig_st;
  enc_status_t                pred_st;
  enc_status_t                res_st;

  // handshake
  assign accept    = item_valid && !item_stall;
  assign coef_load = accept && (mode == MODE_LOAD) && (int'(coef_index) < ORDER);
  assign issue     = (state == S_MAC);
  assign out_free  = !result_valid || !result_stall;
  assign out_load  = (state == S_OUT) && out_free;
  assign enc_start = (state == S_ESTART);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    item_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid && mode == MODE_SAMPLE) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (rd_cnt == CW'(ORDER - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_vld && !s2_vld) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND:  state_next = S_ESTART;
      S_ESTART: state_next = S_EWAIT;
      S_EWAIT: begin
        if (!sig_st.busy && !pred_st.busy && !res_st.busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // coefficient and history memories
  lrme_ram #(.WIDTH(COEF_W), .DEPTH(ORDER)) u_coef_ram (
    .clk   (clk),
    .we    (coef_load),
    .waddr (AW'(coef_index)),
    .wdata (coef_value),
    .raddr (AW'(rd_cnt)),
    .rdata (coef_rdata)
  );

  lrme_ram #(.WIDTH(HIST_W), .DEPTH(ORDER)) u_hist_ram (
    .clk   (clk),
    .we    (out_load),
    .waddr (head_new),
    .wdata (h_sat),
    .raddr (rd_ptr),
    .rdata (hist_rdata)
  );

  // new history slot sits one below the current head
  assign head_new = (head == '0) ? AW'(ORDER - 1) : head - AW'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid   <= '0;
      hist_valid   <= '0;
      head         <= '0;
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      s1_tap0      <= 1'b0;
      last_exc     <= '0;
      result_valid <= 1'b0;
    end else begin
      s1_vld  <= issue;
      s1_tap0 <= issue && (rd_cnt == '0);
      s2_vld  <= s1_vld;
      if (coef_load) begin
        coef_valid[AW'(coef_index)] <= 1'b1;
      end
      if (out_load) begin
        hist_valid[head_new] <= 1'b1;
        head                 <= head_new;
        last_exc             <= exc;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // tap walk: read address and entry valid bits
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_SAMPLE) begin
      rd_cnt   <= '0;
      rd_ptr   <= head;
      sample_q <= sample;
    end else if (issue) begin
      rd_cnt <= rd_cnt + CW'(1);
      rd_ptr <= (rd_ptr == AW'(ORDER - 1)) ? '0 : rd_ptr + AW'(1);
    end
    if (issue) begin
      cv1 <= coef_valid[AW'(rd_cnt)];
      hv1 <= hist_valid[rd_ptr];
    end
  end

  // unwritten entries read as zero
  assign coef_op = cv1 ? $signed(coef_rdata) : '0;
  assign hist_op = hv1 ? $signed(hist_rdata) : '0;

  // multiply, then accumulate
  always_ff @(posedge clk) begin
    if (s1_vld) begin
      prod <= coef_op * hist_op;
    end
    if (accept) begin
      acc <= '0;
    end else if (s2_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // negate, round to Q.4 (ties up), saturate to 24 bits
  assign rnd_sum = RND_W'(2048) - RND_W'(acc);
  assign p_full  = rnd_sum >>> 12;
  always_comb begin
    if (p_full > RND_W'(HIST_MAX)) begin
      p_sat = HIST_W'(HIST_MAX);
    end else if (p_full < RND_W'(HIST_MIN)) begin
      p_sat = HIST_W'(HIST_MIN);
    end else begin
      p_sat = HIST_W'(p_full);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROUND) begin
      p_reg <= p_sat;
    end
  end

  // residual in Q.4
  assign x_val = (X_W'(sample_q) <<< 4) - X_W'(p_reg);

  // compressors: newest history during the tap walk, then prediction and residual
  lrme_mulaw_enc u_enc_sig (
    .clk    (clk),
    .rst    (rst),
    .start  (s1_vld && s1_tap0),
    .value  (X_W'(hist_op)),
    .status (sig_st)
  );

  lrme_mulaw_enc u_enc_pred (
    .clk    (clk),
    .rst    (rst),
    .start  (enc_start),
    .value  (X_W'(p_reg)),
    .status (pred_st)
  );

  lrme_mulaw_enc u_enc_res (
    .clk    (clk),
    .rst    (rst),
    .start  (enc_start),
    .value  (x_val),
    .status (res_st)
  );

  // expand the excitation code and form the new history value
  assign exc     = res_st.code;
  assign dec_idx = exc[7] ? {1'b0, exc[6:0]} : CODE_ZERO - exc;
  always_comb begin
    if (exc[7]) begin
      dec_val = $signed({1'b0, DEC_MAG[dec_idx]});
    end else begin
      dec_val = -$signed({1'b0, DEC_MAG[dec_idx]});
    end
  end

  assign hsum = (HIST_W + 1)'(p_reg) + (HIST_W + 1)'(dec_val);
  always_comb begin
    if (hsum[HIST_W] != hsum[HIST_W-1]) begin
      h_sat = hsum[HIST_W] ? HIST_W'(HIST_MIN) : HIST_W'(HIST_MAX);
    end else begin
      h_sat = hsum[HIST_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      signal_code         <= sig_st.code;
      prediction_code     <= pred_st.code;
      previous_excitation <= last_exc;
      target_excitation   <= exc;
    end
  end

`ifndef SYNTH
  // history entries once written stay valid
  a_hist_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> ((hist_valid & $past(hist_valid)) == $past(hist_valid)))
    else $error("history valid bit cleared");

  // rounding only sees a fully drained accumulator
  a_round_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (!s1_vld && !s2_vld))
    else $error("rounding while products in flight");

  // a result beat appears only out of the output step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT))
    else $error("result raised outside output step");

  // circular buffer head stays inside the order
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    int'(head) < ORDER)
    else $error("history head out of range");

  // no compressor runs while the block waits for a beat
  a_enc_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!sig_st.busy && !pred_st.busy && !res_st.busy))
    else $error("compressor busy while idle");
`endif

endmodule

// ===== bench/tb_lpc_residual_mulaw_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_lpc_residual_mulaw_encoder_top
// Self-checking bench for the LPC residual mu-law encoder. A scoreboard class
// keeps its own copy of the coefficients, history and last excitation, builds
// exact mu-law tables with wide integer arithmetic, and predicts the four
// codes of every sample beat. Directed corner cases come first, then random
// frames of coefficient loads followed by runs of samples, with stray loads
// mixed in. The sender idles in bursts and the receiver stalls on its own
// pattern; every result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_lpc_residual_mulaw_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrme_pkg::*;

  localparam int TAPS        = ORDER_DEF;
  localparam int RANDOM_BEATS = 1250;
  localparam int TAIL_CYCLES = 64;

  typedef logic [1087:0] wide_t;

  // The four codes of one result beat
  typedef struct {
    logic [CODE_W-1:0] signal_code;
    logic [CODE_W-1:0] prediction_code;
    logic [CODE_W-1:0] previous_excitation;
    logic [CODE_W-1:0] target_excitation;
  } code_set_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts codes for accepted input beats, checks result beats
  // --------------------------------------------------------------------------
  class mulaw_scoreboard;
    logic signed [COEF_W-1:0] coefs [TAPS];
    logic signed [HIST_W-1:0] hist  [TAPS];
    logic [CODE_W-1:0]        last_exc;
    longint                   enc_thr [129];  // smallest magnitude per code step
    longint                   dec_mag [129];  // expanded magnitude per code step
    code_set_t                expected_codes [$];
    int                       errors;

    function new();
      longint lo;
      longint hi;
      longint mid;
      wide_t  lim;
      for (int j = 0; j < TAPS; j++) begin
        coefs[j] = '0;
        hist[j]  = '0;
      end
      last_exc = '0;
      errors   = 0;
      // code step m is reached once (2^19 + 255*mag)^32 >= 2^(607 + 2m)
      enc_thr[0] = 0;
      for (int m = 1; m <= 128; m++) begin
        lim = wide_t'(1) << (607 + 2 * m);
        lo  = 0;
        hi  = longint'(1) << 25;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (raise_pow2(wide_t'(longint'(524288) + 255 * mid), 5) >= lim) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        enc_thr[m] = lo;
      end
      // largest mag with (510*mag + 2^20 - 255)^16 < 2^(320 + m)
      for (int m = 0; m <= 128; m++) begin
        lim = wide_t'(1) << (320 + m);
        lo  = 0;
        hi  = 524288;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (raise_pow2(wide_t'(510 * mid + 1048576 - 255), 4) < lim) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
        dec_mag[m] = lo;
      end
    endfunction

    // n^(2^s)
    function wide_t raise_pow2(wide_t n, int s);
      wide_t a;
      a = n;
      for (int k = 0; k < s; k++) begin
        a = a * a;
      end
      return a;
    endfunction

    function longint clamp_q19_4(longint v);
      if (v > HIST_MAX) return HIST_MAX;
      if (v < HIST_MIN) return HIST_MIN;
      return v;
    endfunction

    function logic [CODE_W-1:0] mulaw_code(longint x);
      longint mag;
      int     k;
      mag = (x < 0) ? -x : x;
      k   = 0;
      for (int m = 1; m <= 128; m++) begin
        if (mag >= enc_thr[m]) k = m;
      end
      if (x < 0) return CODE_W'(128 - k);
      if (k > 127) k = 127;
      return CODE_W'(128 + k);
    endfunction

    function longint mulaw_value(logic [CODE_W-1:0] c);
      int u;
      u = int'(c) - 128;
      if (u >= 0) return dec_mag[u];
      return -dec_mag[-u];
    endfunction

    function int pending_count();
      return expected_codes.size();
    endfunction

    // Update the model with one accepted input beat
    function void note_beat(logic m, logic [3:0] idx, logic signed [COEF_W-1:0] cv,
                            logic signed [SAMPLE_W-1:0] smp);
      longint    acc;
      longint    p;
      longint    x;
      code_set_t want;
      logic [CODE_W-1:0] e;
      if (m == MODE_LOAD) begin
        if (int'(idx) < TAPS) coefs[idx] = cv;
        return;
      end
      acc = 0;
      for (int j = 0; j < TAPS; j++) begin
        acc += longint'(coefs[j]) * longint'(hist[j]);
      end
      // negate, round Q.16 to Q.4 with ties up, saturate
      p = clamp_q19_4((-acc + 2048) >>> 12);
      x = longint'(smp) * 16 - p;
      e = mulaw_code(x);
      want.signal_code         = mulaw_code(longint'(hist[0]));
      want.prediction_code     = mulaw_code(p);
      want.previous_excitation = last_exc;
      want.target_excitation   = e;
      expected_codes.push_back(want);
      for (int j = TAPS - 1; j > 0; j--) begin
        hist[j] = hist[j-1];
      end
      hist[0]  = HIST_W'(clamp_q19_4(p + mulaw_value(e)));
      last_exc = e;
    endfunction

    function void report_field(string name, logic [CODE_W-1:0] want,
                               logic [CODE_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_codes(logic [CODE_W-1:0] sig, logic [CODE_W-1:0] pred,
                              logic [CODE_W-1:0] prev, logic [CODE_W-1:0] targ);
      code_set_t want;
      if (expected_codes.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: expected none, actual %0d %0d %0d %0d",
                 $time, sig, pred, prev, targ);
        return;
      end
      want = expected_codes.pop_front();
      report_field("signal_code", want.signal_code, sig);
      report_field("prediction_code", want.prediction_code, pred);
      report_field("previous_excitation", want.previous_excitation, prev);
      report_field("target_excitation", want.target_excitation, targ);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       item_valid   = 1'b0;
  logic                       item_stall;
  logic                       mode         = MODE_LOAD;
  logic [3:0]                 coef_index   = '0;
  logic signed [COEF_W-1:0]   coef_value   = '0;
  logic signed [SAMPLE_W-1:0] sample       = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [CODE_W-1:0]          signal_code;
  logic [CODE_W-1:0]          prediction_code;
  logic [CODE_W-1:0]          previous_excitation;
  logic [CODE_W-1:0]          target_excitation;

  always #10 clk = ~clk;

  lpc_residual_mulaw_encoder_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .item_valid          (item_valid),
    .item_stall          (item_stall),
    .mode                (mode),
    .coef_index          (coef_index),
    .coef_value          (coef_value),
    .sample              (sample),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .signal_code         (signal_code),
    .prediction_code     (prediction_code),
    .previous_excitation (previous_excitation),
    .target_excitation   (target_excitation)
  );

  mulaw_scoreboard sb;

  initial begin
    sb = new();
  end

  // --------------------------------------------------------------------------
  // Result side: check accepted beats, stall on a phased pattern
  // --------------------------------------------------------------------------
  int stall_phase_left = 0;
  int stall_kind       = 0;
  int stall_run        = 0;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_codes(signal_code, prediction_code, previous_excitation, target_excitation);
    end
    if (stall_phase_left == 0) begin
      stall_kind       <= $urandom_range(0, 2);
      stall_phase_left <= $urandom_range(50, 400);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_kind)
      0: begin
        result_stall <= 1'b0;
      end
      1: begin
        result_stall <= $urandom_range(0, 1);
      end
      default: begin
        // long runs of stall and release
        if (stall_run == 0) begin
          result_stall <= !result_stall;
          stall_run    <= $urandom_range(1, 60);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  int beats_sent = 0;
  int burst_left = 0;

  // Drive one beat, wait for acceptance, then idle per the burst pattern
  task automatic send_beat(input logic m, input logic [3:0] idx,
                           input logic signed [COEF_W-1:0] cv,
                           input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    item_valid <= 1'b1;
    mode       <= m;
    coef_index <= idx;
    coef_value <= cv;
    sample     <= smp;
    do @(posedge clk); while (item_stall);
    sb.note_beat(m, idx, cv, smp);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 24);
    end
  endtask

  task automatic load_coef(input logic [3:0] idx, input logic signed [COEF_W-1:0] cv);
    send_beat(MODE_LOAD, idx, cv, SAMPLE_W'($urandom()));
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    send_beat(MODE_SAMPLE, 4'($urandom()), COEF_W'($urandom()), smp);
  endtask

  // Hold off until every expected result beat has arrived
  task automatic drain_results();
    if (sb.pending_count() != 0) begin
      item_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clk);
    end
  endtask

  initial begin
    int                         frame_kind;
    int                         sig_style;
    int                         run_len;
    int                         lim;
    int                         walk;
    logic signed [COEF_W-1:0]   cv;
    logic signed [SAMPLE_W-1:0] smp;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero filter, extreme samples, zero residual
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    // Strongest feedback drives the prediction into saturation and codes to 0
    load_coef(4'd0, -16'sd32768);
    load_coef(4'd15, 16'sd32767);
    send_sample(16'sd32767);
    send_sample(16'sd32767);
    send_sample(16'sd32767);
    // Opposite sign, negative saturation
    load_coef(4'd0, 16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    // Half-step taps give rounding ties
    load_coef(4'd0, 16'sd2048);
    load_coef(4'd15, 16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    load_coef(4'd0, -16'sd2048);
    send_sample(16'sd7);
    send_sample(-16'sd7);
    load_coef(4'd0, 16'sd0);
    send_sample(16'sd0);
    drain_results();

    // Random frames: a coefficient set, then a run of samples
    walk = 0;
    while (beats_sent < RANDOM_BEATS + 25) begin
      if ($urandom_range(0, 7) == 0) drain_results();
      frame_kind = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) begin
        // partial or scattered reload
        repeat ($urandom_range(1, 6)) load_coef(4'($urandom()), COEF_W'($urandom()));
      end else begin
        for (int j = 0; j < TAPS; j++) begin
          if (frame_kind < 4) begin
            // decaying taps
            lim = 3000 >> j;
            if (lim < 16) lim = 16;
            cv = COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
          end else if (frame_kind < 7) begin
            // one or two leading taps, often on half steps
            if (j == 0) begin
              cv = ($urandom_range(0, 1) != 0) ? COEF_W'(($urandom_range(0, 1) != 0) ? 2048 : -2048)
                                               : COEF_W'(int'($urandom_range(0, 7800)) - 3900);
            end else if (j == 1) begin
              cv = COEF_W'(int'($urandom_range(0, 3000)) - 1500);
            end else begin
              cv = '0;
            end
          end else if (frame_kind < 9) begin
            cv = COEF_W'($urandom());
          end else begin
            cv = '0;
          end
          load_coef(4'(j), cv);
        end
      end
      sig_style = $urandom_range(0, 3);
      run_len   = $urandom_range(8, 60);
      for (int n = 0; n < run_len; n++) begin
        if ($urandom_range(0, 11) == 0) begin
          // stray load in the middle of a run
          load_coef(4'($urandom()), COEF_W'($urandom()));
        end
        case (sig_style)
          0: smp = SAMPLE_W'($urandom());
          1: smp = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
          2: begin
            walk = walk + int'($urandom_range(0, 4000)) - 2000;
            if (walk > 32767) walk = 32767;
            if (walk < -32768) walk = -32768;
            smp = SAMPLE_W'(walk);
          end
          default: begin
            case ($urandom_range(0, 3))
              0: smp = 16'sd32767;
              1: smp = -16'sd32768;
              2: smp = 16'sd0;
              default: smp = -16'sd1;
            endcase
          end
        endcase
        send_sample(smp);
      end
    end

    // Wind down
    item_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
